>>> sv/rmpp_pkg.sv
// ----------------------------------------------------------------------------
// rmpp_pkg
// Shared constants, codes and types of the rotated mono pixel packer.
// ----------------------------------------------------------------------------
package rmpp_pkg;

    // default panel geometry (landscape panel, portrait view)
    localparam int PANEL_COLS_DEF = 400;
    localparam int PANEL_ROWS_DEF = 300;

    // raster coordinate width and configuration port widths
    localparam int COORD_W   = 9;
    localparam int CFG_IDX_W = 3;

    // RGB565 threshold and frame store fill value
    localparam logic [15:0] ON_LEVEL  = 16'h7FFF;
    localparam logic [7:0]  FILL_BYTE = 8'hFF;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_WIN_LEFT    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WIN_TOP     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WIN_RIGHT   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_WIN_BOTTOM  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SOURCE_MODE = 3'd4;

    // register reset values
    localparam logic [COORD_W-1:0] WIN_LEFT_RST   = 9'd0;
    localparam logic [COORD_W-1:0] WIN_TOP_RST    = 9'd0;
    localparam logic [COORD_W-1:0] WIN_RIGHT_RST  = 9'd299;
    localparam logic [COORD_W-1:0] WIN_BOTTOM_RST = 9'd399;

    // request kinds
    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_READ  = 1'b1;

    // per-pixel control from the address mapper
    typedef struct packed {
        logic       hit;   // pixel lands on a byte of the store
        logic [7:0] mask;  // bit of that byte
    } pix_ctl_t;

endpackage

>>> sv/rmpp_map.sv
// ----------------------------------------------------------------------------
// rmpp_map
// Maps a portrait view position to a frame store byte address and bit mask:
// clockwise rotation, row flip and 2x4 packing.
// ----------------------------------------------------------------------------
module rmpp_map #(
    parameter int PANEL_COLS = rmpp_pkg::PANEL_COLS_DEF,
    parameter int PANEL_ROWS = rmpp_pkg::PANEL_ROWS_DEF,
    parameter int AW         = 14
) (
    input  logic [rmpp_pkg::COORD_W-1:0] col,
    input  logic [rmpp_pkg::COORD_W-1:0] row,
    output logic [AW-1:0]                addr,
    output rmpp_pkg::pix_ctl_t           ctl
);

    localparam int FS_BYTES = (PANEL_COLS * PANEL_ROWS) / 8;
    localparam int QROWS    = PANEL_ROWS / 4;
    localparam int CW       = $clog2(PANEL_COLS);
    localparam int RW       = $clog2(PANEL_ROWS);
    localparam int IDX_MAX  = ((PANEL_COLS - 1) / 2) * QROWS + (PANEL_ROWS - 1) / 4;
    localparam int IW       = $clog2(IDX_MAX + 1);

    localparam logic [CW-1:0] PC_MAX = CW'(PANEL_COLS - 1);
    localparam logic [RW-1:0] IY_MAX = RW'(PANEL_ROWS - 1);

    logic          in_view;
    logic [CW-1:0] pc;
    logic [RW-1:0] iy;
    logic [IW-1:0] idx;

    assign in_view = (32'(col) < PANEL_ROWS) && (32'(row) < PANEL_COLS);

    // rotate clockwise, then flip the panel row
    assign pc = PC_MAX - CW'(row);
    assign iy = IY_MAX - RW'(col);

    assign idx = IW'(pc[CW-1:1]) * IW'(QROWS) + IW'(iy[RW-1:2]);

    assign addr     = AW'(idx);
    assign ctl.hit  = in_view && (32'(idx) < FS_BYTES);
    assign ctl.mask = 8'h80 >> {iy[1:0], pc[0]};

endmodule

>>> sv/rotated_mono_pixel_packer.sv
// ----------------------------------------------------------------------------
// rotated_mono_pixel_packer
// One-bit panel frame store with rotated raster pixel writes and byte reads.
// ----------------------------------------------------------------------------
// The block takes one request per cycle unless the clearing pass or a stalled
// output holds it off, and returns one result per request through the stage 1
// and output registers. Each pixel write is a read-modify-write of one store
// byte: the memory read issues at acceptance, the byte is modified and written
// back when stage 1 advances, and a request accepted while its byte is written
// takes the new value from a forwarding register. After reset the store is
// filled with 0xFF by a clearing pass over all PANEL_COLS*PANEL_ROWS/8 bytes
// (15000 by default), one byte a cycle; no request is accepted until it ends, while
// configuration writes are taken at any time. Configure only while the block is idle.
// ----------------------------------------------------------------------------
module rotated_mono_pixel_packer #(
    parameter int PANEL_COLS = rmpp_pkg::PANEL_COLS_DEF,
    parameter int PANEL_ROWS = rmpp_pkg::PANEL_ROWS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    // configuration write channel
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [rmpp_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [rmpp_pkg::COORD_W-1:0]   cfg_data,
    // request stream
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [31:0]                    s_axis_tdata,  // pixel_value, read_index, pad
    input  logic                           s_axis_tuser,  // req_type
    // result stream
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [7:0]                     m_axis_tdata,  // read_byte
    output logic                           m_axis_tlast,  // window_done
    output logic                           m_axis_tuser   // read_bad
);

    localparam int FS_BYTES = (PANEL_COLS * PANEL_ROWS) / 8;
    localparam int AW       = $clog2(FS_BYTES);
    localparam int XW       = rmpp_pkg::COORD_W;

    localparam logic [AW-1:0] LAST_ADDR = AW'(FS_BYTES - 1);

    // request fields
    logic        req_type;
    logic [15:0] pixel_value;
    logic [13:0] read_index;

    assign req_type    = s_axis_tuser;
    assign pixel_value = s_axis_tdata[15:0];
    assign read_index  = s_axis_tdata[29:16];

    // configuration and raster
    logic [XW-1:0] win_left_reg, win_left_next;
    logic [XW-1:0] win_top_reg, win_top_next;
    logic [XW-1:0] win_right_reg, win_right_next;
    logic [XW-1:0] win_bottom_reg, win_bottom_next;
    logic          source_mode_reg, source_mode_next;
    logic [XW-1:0] raster_col_reg, raster_col_next;
    logic [XW-1:0] raster_row_reg, raster_row_next;
    logic          done_now;

    // clearing pass
    logic          clearing_reg, clearing_next;
    logic [AW-1:0] clr_addr_reg, clr_addr_next;

    // stage 1: byte read in flight
    logic          s1_valid_reg, s1_valid_next;
    logic          s1_read_reg;
    logic          s1_bad_reg;
    logic          s1_on_reg;
    logic          s1_done_reg;
    logic [AW-1:0] s1_addr_reg;
    rmpp_pkg::pix_ctl_t s1_ctl_reg;

    // forwarding of the last pixel write
    logic          fwd_valid_reg, fwd_valid_next;
    logic [AW-1:0] fwd_addr_reg;
    logic [7:0]    fwd_data_reg;

    // output register
    logic          out_valid_reg, out_valid_next;
    logic [7:0]    out_byte_reg;
    logic          out_done_reg;
    logic          out_bad_reg;

    // memory
    logic [7:0]    mem [FS_BYTES];
    logic [7:0]    rdata_reg;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [7:0]    mem_wdata;
    logic [AW-1:0] raddr;

    logic          accept;
    logic          cfg_fire;
    logic          s1_adv;
    logic          s1_we;
    logic          pix_on;
    logic          rd_bad;
    logic [7:0]    s1_cur;
    logic [7:0]    s1_new;
    logic [AW-1:0] map_addr;
    rmpp_pkg::pix_ctl_t map_ctl;

    rmpp_map #(
        .PANEL_COLS (PANEL_COLS),
        .PANEL_ROWS (PANEL_ROWS),
        .AW         (AW)
    ) u_map (
        .col  (raster_col_reg),
        .row  (raster_row_reg),
        .addr (map_addr),
        .ctl  (map_ctl)
    );

    assign cfg_ready     = 1'b1;
    assign cfg_fire      = cfg_valid && cfg_ready;
    assign s1_adv        = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = !clearing_reg && (!s1_valid_reg || s1_adv);
    assign accept        = s_axis_tvalid && s_axis_tready;

    assign pix_on = source_mode_reg ? pixel_value[0] : (pixel_value >= rmpp_pkg::ON_LEVEL);
    assign rd_bad = 32'(read_index) >= FS_BYTES;
    assign raddr  = (req_type == rmpp_pkg::REQ_READ) ? AW'(read_index) : map_addr;

    // raster advance and configuration
    always_comb
    begin
        win_left_next    = win_left_reg;
        win_top_next     = win_top_reg;
        win_right_next   = win_right_reg;
        win_bottom_next  = win_bottom_reg;
        source_mode_next = source_mode_reg;
        raster_col_next  = raster_col_reg;
        raster_row_next  = raster_row_reg;
        done_now         = 1'b0;

        if (accept && req_type == rmpp_pkg::REQ_WRITE)
        begin
            if (raster_col_reg >= win_right_reg)
            begin
                raster_col_next = win_left_reg;
                if (raster_row_reg >= win_bottom_reg)
                begin
                    raster_row_next = win_top_reg;
                    done_now        = 1'b1;
                end
                else
                begin
                    raster_row_next = raster_row_reg + XW'(1);
                end
            end
            else
            begin
                raster_col_next = raster_col_reg + XW'(1);
            end
        end

        if (cfg_fire)
        begin
            case (cfg_index)
                rmpp_pkg::REG_WIN_LEFT:    win_left_next    = cfg_data;
                rmpp_pkg::REG_WIN_TOP:     win_top_next     = cfg_data;
                rmpp_pkg::REG_WIN_RIGHT:   win_right_next   = cfg_data;
                rmpp_pkg::REG_WIN_BOTTOM:  win_bottom_next  = cfg_data;
                rmpp_pkg::REG_SOURCE_MODE: source_mode_next = cfg_data[0];
                default: ;
            endcase
            // window writes restart the raster
            if (cfg_index inside {rmpp_pkg::REG_WIN_LEFT, rmpp_pkg::REG_WIN_TOP,
                                  rmpp_pkg::REG_WIN_RIGHT, rmpp_pkg::REG_WIN_BOTTOM})
            begin
                raster_col_next = win_left_next;
                raster_row_next = win_top_next;
            end
        end
    end

    // stage 1 modify: take the byte just written when it is the same one
    assign s1_cur = (fwd_valid_reg && fwd_addr_reg == s1_addr_reg) ? fwd_data_reg : rdata_reg;
    assign s1_new = s1_on_reg ? (s1_cur | s1_ctl_reg.mask) : (s1_cur & ~s1_ctl_reg.mask);
    assign s1_we  = s1_valid_reg && s1_adv && !s1_read_reg && s1_ctl_reg.hit;

    assign mem_we    = clearing_reg || s1_we;
    assign mem_waddr = clearing_reg ? clr_addr_reg : s1_addr_reg;
    assign mem_wdata = clearing_reg ? rmpp_pkg::FILL_BYTE : s1_new;

    always_comb
    begin
        clearing_next = clearing_reg;
        clr_addr_next = clr_addr_reg;
        if (clearing_reg)
        begin
            clr_addr_next = clr_addr_reg + AW'(1);
            if (clr_addr_reg == LAST_ADDR)
            begin
                clearing_next = 1'b0;
            end
        end

        s1_valid_next = s1_valid_reg;
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_adv)
        begin
            s1_valid_next = 1'b0;
        end

        fwd_valid_next = fwd_valid_reg || s1_we;

        out_valid_next = out_valid_reg;
        if (s1_valid_reg && s1_adv)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_left_reg    <= rmpp_pkg::WIN_LEFT_RST;
            win_top_reg     <= rmpp_pkg::WIN_TOP_RST;
            win_right_reg   <= rmpp_pkg::WIN_RIGHT_RST;
            win_bottom_reg  <= rmpp_pkg::WIN_BOTTOM_RST;
            source_mode_reg <= 1'b0;
            raster_col_reg  <= rmpp_pkg::WIN_LEFT_RST;
            raster_row_reg  <= rmpp_pkg::WIN_TOP_RST;
            clearing_reg    <= 1'b1;
            clr_addr_reg    <= '0;
            s1_valid_reg    <= 1'b0;
            fwd_valid_reg   <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            win_left_reg    <= win_left_next;
            win_top_reg     <= win_top_next;
            win_right_reg   <= win_right_next;
            win_bottom_reg  <= win_bottom_next;
            source_mode_reg <= source_mode_next;
            raster_col_reg  <= raster_col_next;
            raster_row_reg  <= raster_row_next;
            clearing_reg    <= clearing_next;
            clr_addr_reg    <= clr_addr_next;
            s1_valid_reg    <= s1_valid_next;
            fwd_valid_reg   <= fwd_valid_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_read_reg <= (req_type == rmpp_pkg::REQ_READ);
            s1_bad_reg  <= rd_bad;
            s1_on_reg   <= pix_on;
            s1_done_reg <= done_now;
            s1_addr_reg <= raddr;
            s1_ctl_reg  <= map_ctl;
        end
        if (s1_we)
        begin
            fwd_addr_reg <= s1_addr_reg;
            fwd_data_reg <= s1_new;
        end
        if (s1_valid_reg && s1_adv)
        begin
            out_byte_reg <= (s1_read_reg && !s1_bad_reg) ? s1_cur : 8'h00;
            out_done_reg <= !s1_read_reg && s1_done_reg;
            out_bad_reg  <= s1_read_reg && s1_bad_reg;
        end
    end

    // frame store
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (accept)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_byte_reg;
    assign m_axis_tlast  = out_done_reg;
    assign m_axis_tuser  = out_bad_reg;

`ifndef SYNTH
    // hold requests off while the store is being filled
    a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        clearing_reg |-> !s_axis_tready)
        else $error("request accepted during clearing pass");

    // a pixel write back never races the clearing pass
    a_we_after_clear: assert property (@(posedge clk) disable iff (!rst_n)
        s1_we |-> !clearing_reg)
        else $error("pixel write during clearing pass");

    // a bad read carries a zero byte and never ends a window
    a_bad_read_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata == 8'h00 && !m_axis_tlast))
        else $error("bad read result carries data or window end");

    // a full pipe with a stalled output takes no new request
    a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && out_valid_reg && !m_axis_tready) |-> !s_axis_tready)
        else $error("request accepted with stage 1 blocked");

    // stage 1 drains into the output register once it is free
    a_s1_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !out_valid_reg) |=> out_valid_reg)
        else $error("stage 1 result lost");
`endif

endmodule

>>> tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the rotated mono pixel packer.
// ----------------------------------------------------------------------------
// A local predictor holds its own frame store copy, window registers and
// raster position. It computes the result of every request at acceptance and
// queues it. The checker compares each result against the oldest queued one.
// Directed tests cover the fresh store, the RGB565 threshold, the one-bit
// source, inverted and off-view windows, and writes to unknown registers.
// Random traffic then streams pixel windows mixed with byte reads under three
// idle and stall profiles.
// ----------------------------------------------------------------------------
module testbench;

    localparam int STORE_BYTES   = rmpp_pkg::PANEL_COLS_DEF * rmpp_pkg::PANEL_ROWS_DEF / 8;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int SETTLE_CYCLES = 6;
    localparam int CW            = rmpp_pkg::COORD_W;
    localparam int IXW           = rmpp_pkg::CFG_IDX_W;

    typedef struct packed {
        logic [7:0] rd_byte;
        logic       done;
        logic       bad;
    } result_t;

    logic           clk = 1'b0;
    logic           rst_n;
    logic           cfg_valid;
    logic           cfg_ready;
    logic [IXW-1:0] cfg_index;
    logic [CW-1:0]  cfg_data;
    logic           s_axis_tvalid;
    logic           s_axis_tready;
    logic [31:0]    s_axis_tdata;
    logic           s_axis_tuser;
    logic           m_axis_tvalid;
    logic           m_axis_tready = 1'b0;
    logic [7:0]     m_axis_tdata;
    logic           m_axis_tlast;
    logic           m_axis_tuser;

    // predictor state
    logic [7:0]    frame_copy [STORE_BYTES];
    logic [CW-1:0] win_left_q;
    logic [CW-1:0] win_top_q;
    logic [CW-1:0] win_right_q;
    logic [CW-1:0] win_bottom_q;
    logic [CW-1:0] col_q;
    logic [CW-1:0] row_q;
    logic          mode_q;
    int            last_idx;
    result_t       pending_results [$];

    int send_gap_pct;
    int recv_stall_pct;
    int mismatch_count = 0;
    int cycle_count = 0;

    rotated_mono_pixel_packer u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    function automatic void note_mismatch(string what, result_t want, result_t got);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("mismatch (%s): expected byte=%02h done=%0b bad=%0b, %s%02h done=%0b bad=%0b",
                     what, want.rd_byte, want.done, want.bad, "got byte=",
                     got.rd_byte, got.done, got.bad);
    endfunction

    // compute the result of one accepted request and advance the local state
    task automatic predict_request(input logic kind, input logic [15:0] pix,
                                   input logic [13:0] idx);
        result_t r;
        logic    on;
        int      pc;
        int      iy;
        int      addr;
        int      bitpos;
        r = '0;
        if (kind == rmpp_pkg::REQ_READ)
        begin
            if (idx < STORE_BYTES)
                r.rd_byte = frame_copy[idx];
            else
                r.bad = 1'b1;
        end
        else
        begin
            on = mode_q ? pix[0] : (pix >= rmpp_pkg::ON_LEVEL);
            if (col_q < rmpp_pkg::PANEL_ROWS_DEF && row_q < rmpp_pkg::PANEL_COLS_DEF)
            begin
                // rotate clockwise, then flip the panel row
                pc     = rmpp_pkg::PANEL_COLS_DEF - 1 - int'(row_q);
                iy     = rmpp_pkg::PANEL_ROWS_DEF - 1 - int'(col_q);
                addr   = (pc / 2) * (rmpp_pkg::PANEL_ROWS_DEF / 4) + iy / 4;
                bitpos = 7 - ((iy % 4) * 2 + pc % 2);
                frame_copy[14'(addr)][3'(bitpos)] = on;
                last_idx = addr;
            end
            if (col_q >= win_right_q)
            begin
                col_q = win_left_q;
                if (row_q >= win_bottom_q)
                begin
                    row_q  = win_top_q;
                    r.done = 1'b1;
                end
                else
                    row_q = row_q + CW'(1);
            end
            else
                col_q = col_q + CW'(1);
        end
        pending_results.push_back(r);
    endtask

    // result checker and receiver stall
    always @(posedge clk)
    begin
        result_t got;
        result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = '{rd_byte: m_axis_tdata, done: m_axis_tlast, bad: m_axis_tuser};
            if (pending_results.size() == 0)
                note_mismatch("no request pending", '0, got);
            else
            begin
                want = pending_results.pop_front();
                if (got.rd_byte !== want.rd_byte)
                    note_mismatch("read_byte", want, got);
                else if (got.done !== want.done)
                    note_mismatch("window_done", want, got);
                else if (got.bad !== want.bad)
                    note_mismatch("read_bad", want, got);
            end
        end
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // keep tvalid high after acceptance; drop it only for a gap
    task automatic send_request(input logic kind, input logic [15:0] pix,
                                input logic [13:0] idx);
        while ($urandom_range(99) < send_gap_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= {2'b00, idx, pix};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        predict_request(kind, pix, idx);
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_reg(input logic [IXW-1:0] index, input logic [CW-1:0] value);
        drain_results();
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        case (index)
            rmpp_pkg::REG_WIN_LEFT:    win_left_q   = value;
            rmpp_pkg::REG_WIN_TOP:     win_top_q    = value;
            rmpp_pkg::REG_WIN_RIGHT:   win_right_q  = value;
            rmpp_pkg::REG_WIN_BOTTOM:  win_bottom_q = value;
            rmpp_pkg::REG_SOURCE_MODE: mode_q       = value[0];
            default: ;
        endcase
        // window registers restart the raster
        if (index <= rmpp_pkg::REG_WIN_BOTTOM)
        begin
            col_q = win_left_q;
            row_q = win_top_q;
        end
        @(posedge clk);
    endtask

    task automatic set_window(input int l, input int t, input int r, input int b);
        set_reg(rmpp_pkg::REG_WIN_LEFT, CW'(l));
        set_reg(rmpp_pkg::REG_WIN_TOP, CW'(t));
        set_reg(rmpp_pkg::REG_WIN_RIGHT, CW'(r));
        set_reg(rmpp_pkg::REG_WIN_BOTTOM, CW'(b));
    endtask

    task automatic send_pixel(input logic [15:0] pix);
        send_request(rmpp_pkg::REQ_WRITE, pix, 14'($urandom_range(16383)));
    endtask

    task automatic send_read(input logic [13:0] idx);
        send_request(rmpp_pkg::REQ_READ, 16'($urandom_range(65535)), idx);
    endtask

    function automatic logic [15:0] pick_pixel_value();
        case ($urandom_range(5))
            0:       return rmpp_pkg::ON_LEVEL;
            1:       return rmpp_pkg::ON_LEVEL - 16'd1;
            2:       return 16'h0000;
            3:       return 16'hFFFF;
            default: return 16'($urandom_range(65535));
        endcase
    endfunction

    function automatic logic [13:0] pick_read_index();
        case ($urandom_range(4))
            0, 1:    return 14'(last_idx);
            2:       return 14'($urandom_range(STORE_BYTES - 1));
            3:       return 14'($urandom_range(16383));
            default: return 14'($urandom_range(STORE_BYTES + 3, STORE_BYTES - 4));
        endcase
    endfunction

    task automatic load_random_window();
        int l;
        int t;
        int r;
        int b;
        case ($urandom_range(9))
            0:
            begin
                l = 0;
                t = 0;
                r = rmpp_pkg::PANEL_ROWS_DEF - 1;
                b = rmpp_pkg::PANEL_COLS_DEF - 1;
            end
            1:
            begin
                // inverted: every pixel ends a row or the window
                l = $urandom_range(511, 1);
                r = $urandom_range(l - 1);
                t = $urandom_range(511);
                b = $urandom_range(511);
            end
            2:
            begin
                l = $urandom_range(511, 280);
                t = $urandom_range(511, 380);
                r = l + $urandom_range(15);
                b = t + $urandom_range(7);
            end
            3:
            begin
                l = $urandom_range(3);
                t = $urandom_range(3);
                r = l + $urandom_range(9);
                b = t + $urandom_range(5);
            end
            4:
            begin
                r = rmpp_pkg::PANEL_ROWS_DEF - 1;
                b = rmpp_pkg::PANEL_COLS_DEF - 1;
                l = r - $urandom_range(9);
                t = b - $urandom_range(5);
            end
            default:
            begin
                l = $urandom_range(rmpp_pkg::PANEL_ROWS_DEF - 1);
                t = $urandom_range(rmpp_pkg::PANEL_COLS_DEF - 1);
                r = l + $urandom_range(9);
                b = t + $urandom_range(7);
            end
        endcase
        if (r > 511)
            r = 511;
        if (b > 511)
            b = 511;
        set_window(l, t, r, b);
        set_reg(rmpp_pkg::REG_SOURCE_MODE, CW'($urandom_range(511)));
        if ($urandom_range(5) == 0)
            set_reg(IXW'(rmpp_pkg::REG_SOURCE_MODE + 1 + $urandom_range(2)),
                    CW'($urandom_range(511)));
    endtask

    task automatic test_fresh_store();
        send_read(14'd0);
        send_read(14'(STORE_BYTES - 1));
        send_read(14'(STORE_BYTES));
        send_read(14'h3FFF);
    endtask

    task automatic test_threshold();
        set_window(0, 0, 1, 1);
        set_reg(rmpp_pkg::REG_SOURCE_MODE, CW'(0));
        send_pixel(16'h0000);
        send_pixel(rmpp_pkg::ON_LEVEL - 16'd1);
        send_pixel(rmpp_pkg::ON_LEVEL);
        send_pixel(16'hFFFF);
        send_read(14'(last_idx));
    endtask

    task automatic test_bit_mode();
        set_reg(rmpp_pkg::REG_SOURCE_MODE, CW'(1));
        send_pixel(16'hFFFE);
        send_pixel(16'h0001);
        send_read(14'(last_idx));
    endtask

    task automatic test_inverted_window();
        set_window(5, 7, 2, 3);
        send_pixel(16'h0000);
        send_pixel(16'h0001);
        send_read(14'(last_idx));
    endtask

    task automatic test_outside_view();
        set_window(rmpp_pkg::PANEL_ROWS_DEF - 1, rmpp_pkg::PANEL_COLS_DEF - 1,
                   rmpp_pkg::PANEL_ROWS_DEF, rmpp_pkg::PANEL_COLS_DEF);
        send_pixel(16'h0000);
        send_pixel(16'h0001);
        send_pixel(16'h0001);
        send_pixel(16'h0001);
        send_read(14'd0);
        // all-ones window registers
        set_window(511, 511, 511, 511);
        send_pixel(16'h0001);
    endtask

    task automatic test_unknown_registers();
        set_window(0, 0, 2, 0);
        set_reg(rmpp_pkg::REG_SOURCE_MODE, CW'(0));
        send_pixel(16'h0000);
        // unknown indexes must leave the raster alone
        set_reg(rmpp_pkg::REG_SOURCE_MODE + 3'd1, 9'h1FF);
        set_reg(rmpp_pkg::REG_SOURCE_MODE + 3'd2, 9'h1FF);
        set_reg(rmpp_pkg::REG_SOURCE_MODE + 3'd3, 9'h1FF);
        send_pixel(16'h0000);
        send_pixel(16'hFFFF);
        send_read(14'(last_idx));
    endtask

    task automatic test_random_traffic(input int windows);
        int w;
        int k;
        int count;
        for (w = 0; w < windows; w++)
        begin
            load_random_window();
            count = $urandom_range(85, 30);
            for (k = 0; k < count; k++)
            begin
                if ($urandom_range(99) < 15)
                    send_read(pick_read_index());
                else
                    send_pixel(pick_pixel_value());
            end
        end
    endtask

    initial
    begin
        rst_n         <= 1'b0;
        cfg_valid     <= 1'b0;
        cfg_index     <= rmpp_pkg::REG_WIN_LEFT;
        cfg_data      <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= rmpp_pkg::REQ_WRITE;
        foreach (frame_copy[i])
            frame_copy[i] = rmpp_pkg::FILL_BYTE;
        win_left_q     = rmpp_pkg::WIN_LEFT_RST;
        win_top_q      = rmpp_pkg::WIN_TOP_RST;
        win_right_q    = rmpp_pkg::WIN_RIGHT_RST;
        win_bottom_q   = rmpp_pkg::WIN_BOTTOM_RST;
        mode_q         = 1'b0;
        col_q          = rmpp_pkg::WIN_LEFT_RST;
        row_q          = rmpp_pkg::WIN_TOP_RST;
        last_idx       = 0;
        send_gap_pct   = 17;
        recv_stall_pct = 70;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        test_fresh_store();
        test_threshold();
        test_bit_mode();
        test_inverted_window();
        test_outside_view();
        test_unknown_registers();

        test_random_traffic(10);
        drain_results();
        send_gap_pct   = 70;
        recv_stall_pct = 17;
        test_random_traffic(10);
        drain_results();
        send_gap_pct   = 0;
        recv_stall_pct = 0;
        test_random_traffic(10);
        drain_results();

        if (mismatch_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

>>> filelist.f
sv/rmpp_pkg.sv
sv/rmpp_map.sv
sv/rotated_mono_pixel_packer.sv
tb/testbench.sv
